// ----- rtl/tccw_pkg.sv -----
// tccw_pkg: shared types, codes and default sizes for the text console writer
// no dependencies; imported by every module of the block

package tccw_pkg;

    // default screen geometry
    localparam int DEF_COLUMNS   = 80;
    localparam int DEF_ROWS      = 25;
    localparam int DEF_TAB_WIDTH = 8;

    // fixed field widths
    localparam int POS_W  = 11;
    localparam int DATA_W = 16;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;

    // reset attribute: light grey on black
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    // operation codes
    localparam logic OP_PRINT = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // control characters
    localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_RETURN  = 8'd13;

    typedef enum logic [1:0] {
        KIND_PRINT,
        KIND_NEWLINE,
        KIND_RETURN,
        KIND_TAB
    } char_kind_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CALC,
        ST_UPDATE,
        ST_SCROLL,
        ST_DONE
    } seq_state_t;

    // sequencer to cursor unit
    typedef struct packed {
        logic       calc;
        logic       update;
        char_kind_t kind;
    } cur_cmd_t;

    function automatic char_kind_t char_kind(input logic [CHAR_W-1:0] ch);
        char_kind_t k;
        case (ch)
            CHAR_NEWLINE: k = KIND_NEWLINE;
            CHAR_RETURN:  k = KIND_RETURN;
            CHAR_TAB:     k = KIND_TAB;
            default:      k = KIND_PRINT;
        endcase
        return k;
    endfunction

endpackage

// ----- rtl/text_console_char_writer.sv -----
// channel     | valid    | stall     | payload
// input       | in_valid | in_stall  | operation, char_code, cell_index
// result      | out_valid| out_stall | cursor_pos, read_data, scrolled
// attribute   | cfg_write_en (no handshake) | cfg_write_data
//
// a read transaction steps through accept, ram read and result; a print through accept,
// tab stop, cursor update and result; the cursor arithmetic and the single ram read port set these steps
// a print that scrolls adds a sweep in which the ram moves one cell per cycle
// after reset a clearing pass zeroes the screen, input stalled
// the next transaction is taken while the result register still waits on out_stall
//
// top level of the text console writer; depends on tccw_pkg, tccw_screen_ram,
// tccw_cursor and tccw_seq

module text_console_char_writer
    import tccw_pkg::*;
#(
    parameter int COLUMNS   = DEF_COLUMNS,
    parameter int ROWS      = DEF_ROWS,
    parameter int TAB_WIDTH = DEF_TAB_WIDTH
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [ATTR_W-1:0] cfg_write_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              operation,
    input  logic [CHAR_W-1:0] char_code,
    input  logic [POS_W-1:0]  cell_index,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [POS_W-1:0]  cursor_pos,
    output logic [DATA_W-1:0] read_data,
    output logic              scrolled
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);

    logic [ATTR_W-1:0] attr_reg;
    logic [AW-1:0]     cursor;
    logic              wrap;
    cur_cmd_t          cmd;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    // attribute register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= ATTR_RESET;
        end
        else if (cfg_write_en)
        begin
            attr_reg <= cfg_write_data;
        end
    end

    tccw_screen_ram #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    tccw_cursor #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_cursor (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .cursor (cursor),
        .wrap   (wrap)
    );

    tccw_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .char_code  (char_code),
        .cell_index (cell_index),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cursor_pos (cursor_pos),
        .read_data  (read_data),
        .scrolled   (scrolled),
        .attr       (attr_reg),
        .cursor     (cursor),
        .wrap       (wrap),
        .cmd        (cmd),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

endmodule

// ----- rtl/tccw_screen_ram.sv -----
// tccw_screen_ram: screen cell store, one write port and one registered read port
// depends on tccw_pkg for the cell width

module tccw_screen_ram
    import tccw_pkg::*;
#(
    parameter int DEPTH = DEF_COLUMNS * DEF_ROWS,
    parameter int AW    = $clog2(DEF_COLUMNS * DEF_ROWS)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/tccw_cursor.sv -----
// tccw_cursor: cursor and column registers with next-position arithmetic
// depends on tccw_pkg; tab stops found by reciprocal multiply with one correction

module tccw_cursor
    import tccw_pkg::*;
#(
    parameter int COLUMNS   = DEF_COLUMNS,
    parameter int ROWS      = DEF_ROWS,
    parameter int TAB_WIDTH = DEF_TAB_WIDTH
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  cur_cmd_t                             cmd,
    output logic [$clog2(COLUMNS * ROWS)-1:0]    cursor,
    output logic                                 wrap
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = AW + 1;
    localparam int CW    = $clog2(COLUMNS);
    localparam logic [AW-1:0] TAB_M = AW'((1 << AW) / TAB_WIDTH);

    logic [AW-1:0]   cursor_reg;
    logic [AW-1:0]   cursor_next;
    logic [CW-1:0]   col_reg;
    logic [CW-1:0]   col_next;
    logic [2*AW-1:0] prod_reg;
    logic [XW-1:0]   t0_reg;

    logic [AW-1:0] q0;
    logic [XW-1:0] p;
    logic [XW-1:0] colx;
    logic [XW-1:0] row_next;
    logic [XW-1:0] tab_stop;
    logic [XW-1:0] p_new;
    logic [XW-1:0] col_wide;

    // cursor times reciprocal of the tab width, free running
    always_ff @(posedge clk)
    begin
        prod_reg <= (2*AW)'(cursor_reg) * (2*AW)'(TAB_M);
    end

    assign q0 = prod_reg[2*AW-1:AW];

    // candidate tab stop, may still be one stop short
    always_ff @(posedge clk)
    begin
        if (cmd.calc)
        begin
            t0_reg <= XW'(q0) * XW'(TAB_WIDTH) + XW'(TAB_WIDTH);
        end
    end

    // next position for the pending character
    always_comb
    begin
        p        = XW'(cursor_reg);
        colx     = XW'(col_reg);
        row_next = p + XW'(COLUMNS) - colx;
        tab_stop = (t0_reg <= p) ? t0_reg + XW'(TAB_WIDTH) : t0_reg;
        p_new    = p;
        col_wide = colx;
        case (cmd.kind)
            KIND_PRINT:
            begin
                p_new    = p + XW'(1);
                col_wide = (col_reg == CW'(COLUMNS - 1)) ? '0 : colx + XW'(1);
            end
            KIND_NEWLINE:
            begin
                p_new    = row_next;
                col_wide = '0;
            end
            KIND_RETURN:
            begin
                p_new    = p - colx;
                col_wide = '0;
            end
            KIND_TAB:
            begin
                if (tab_stop < row_next)
                begin
                    p_new    = tab_stop;
                    col_wide = colx + (tab_stop - p);
                end
                else
                begin
                    p_new    = row_next;
                    col_wide = '0;
                end
            end
            default:
            begin
                p_new    = p;
                col_wide = colx;
            end
        endcase
        wrap        = cmd.update && (p_new >= XW'(CELLS));
        cursor_next = wrap ? AW'(p_new - XW'(COLUMNS)) : p_new[AW-1:0];
        col_next    = col_wide[CW-1:0];
    end

    // cursor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
            col_reg    <= '0;
        end
        else if (cmd.update)
        begin
            cursor_reg <= cursor_next;
            col_reg    <= col_next;
        end
    end

    assign cursor = cursor_reg;

endmodule

// ----- rtl/tccw_seq.sv -----
// tccw_seq: transaction sequencer, clear and scroll sweeps, result register
// depends on tccw_pkg; drives the screen ram ports and the cursor unit

module tccw_seq
    import tccw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              operation,
    input  logic [CHAR_W-1:0]                 char_code,
    input  logic [POS_W-1:0]                  cell_index,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [POS_W-1:0]                  cursor_pos,
    output logic [DATA_W-1:0]                 read_data,
    output logic                              scrolled,
    input  logic [ATTR_W-1:0]                 attr,
    input  logic [$clog2(COLUMNS * ROWS)-1:0] cursor,
    input  logic                              wrap,
    output cur_cmd_t                          cmd,
    output logic                              ram_we,
    output logic [$clog2(COLUMNS * ROWS)-1:0] ram_waddr,
    output logic [DATA_W-1:0]                 ram_wdata,
    output logic [$clog2(COLUMNS * ROWS)-1:0] ram_raddr,
    input  logic [DATA_W-1:0]                 ram_rdata
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = AW + 1;
    localparam int WW    = AW + POS_W;

    seq_state_t state_reg;
    seq_state_t state_next;

    logic [XW-1:0]     cnt_reg;
    char_kind_t        kind_reg;
    logic              in_range_reg;
    logic [DATA_W-1:0] rd_val_reg;
    logic              scr_reg;
    logic              out_valid_reg;
    logic [POS_W-1:0]  cursor_pos_reg;
    logic [DATA_W-1:0] read_data_reg;
    logic              scrolled_reg;

    logic [WW-1:0] idx_w;
    logic [WW-1:0] cur_w;
    logic [XW-1:0] cnt_m1;
    logic [XW-1:0] src_addr;
    logic          accept;
    logic          out_load;

    assign idx_w    = WW'(cell_index);
    assign cur_w    = WW'(cursor);
    assign cnt_m1   = cnt_reg - XW'(1);
    assign src_addr = cnt_reg + XW'(COLUMNS);
    assign accept   = (state_reg == ST_IDLE) && in_valid;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (cnt_reg == XW'(CELLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (operation == OP_READ) ? ST_READ : ST_CALC;
                end
            end
            ST_READ:   state_next = ST_DONE;
            ST_CALC:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = wrap ? ST_SCROLL : ST_DONE;
            ST_SCROLL:
            begin
                if (cnt_reg == XW'(CELLS))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_CLEAR;
        endcase
    end

    // outputs per state: handshake, cursor commands, ram ports
    always_comb
    begin
        in_stall   = 1'b1;
        cmd.calc   = 1'b0;
        cmd.update = 1'b0;
        cmd.kind   = kind_reg;
        ram_we     = 1'b0;
        ram_waddr  = cursor;
        ram_wdata  = {attr, char_code};
        ram_raddr  = idx_w[AW-1:0];
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[AW-1:0];
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                ram_we   = in_valid && (operation == OP_PRINT)
                           && (char_kind(char_code) == KIND_PRINT);
            end
            ST_CALC:
            begin
                cmd.calc = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            ST_SCROLL:
            begin
                // read one row below, write the cell read in the cycle before
                ram_raddr = (src_addr < XW'(CELLS)) ? src_addr[AW-1:0] : '0;
                ram_we    = (cnt_reg != '0);
                ram_waddr = cnt_m1[AW-1:0];
                ram_wdata = (cnt_m1 < XW'(CELLS - COLUMNS)) ? ram_rdata : '0;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // state register and sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                cnt_reg <= (cnt_reg == XW'(CELLS - 1)) ? '0 : cnt_reg + XW'(1);
            end
            else if (state_reg == ST_SCROLL)
            begin
                cnt_reg <= (cnt_reg == XW'(CELLS)) ? '0 : cnt_reg + XW'(1);
            end
        end
    end

    // per-transaction working values
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg     <= char_kind(char_code);
            in_range_reg <= (idx_w < WW'(CELLS));
            rd_val_reg   <= '0;
            scr_reg      <= 1'b0;
        end
        if (state_reg == ST_READ)
        begin
            rd_val_reg <= in_range_reg ? ram_rdata : '0;
        end
        if (state_reg == ST_UPDATE)
        begin
            scr_reg <= wrap;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            cursor_pos_reg <= cur_w[POS_W-1:0];
            read_data_reg  <= rd_val_reg;
            scrolled_reg   <= scr_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cursor_pos = cursor_pos_reg;
    assign read_data  = read_data_reg;
    assign scrolled   = scrolled_reg;

endmodule

// ----- rtl/tccw_checker.sv -----
// tccw_checker: port-level checks on the text console writer
// depends on tccw_pkg; bound to text_console_char_writer below

module tccw_checker
    import tccw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic [POS_W-1:0]  cursor_pos,
    input logic [DATA_W-1:0] read_data,
    input logic              scrolled
);

    localparam logic [POS_W-1:0] SCROLL_POS = POS_W'(COLUMNS * ROWS - COLUMNS);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(cursor_pos) && $stable(read_data)
                                   && $stable(scrolled))
        else $error("result payload changed while stalled");

    // one transaction at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken back to back");

    // a scroll always leaves the cursor at the start of the bottom row
    a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scrolled |-> cursor_pos == SCROLL_POS)
        else $error("cursor not on bottom row after scroll");

    // only prints scroll, and prints return no cell data
    a_scroll_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && scrolled |-> read_data == '0)
        else $error("scrolling transaction returned cell data");

endmodule

bind text_console_char_writer tccw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cursor_pos (cursor_pos),
    .read_data  (read_data),
    .scrolled   (scrolled)
);

// ----- sim/tb_text_console_char_writer.sv -----
// testbench for the text console writer: prints, tabs, returns, newlines, scrolls and reads
// drives both valid/stall channels and the attribute register; depends on tccw_pkg and the rtl
`timescale 1ns / 1ps

module tb_text_console_char_writer
    import tccw_pkg::*;
();

    localparam int COLS  = DEF_COLUMNS;
    localparam int ROWS  = DEF_ROWS;
    localparam int TABW  = DEF_TAB_WIDTH;
    localparam int CELLS = COLS * ROWS;

    // one expected result transaction
    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] data;
        logic              scr;
    } console_result_t;

    // screen and cursor predictor plus the queue of expected results
    class console_scoreboard;
        logic [DATA_W-1:0] cells [CELLS];
        int unsigned       cur;
        logic [ATTR_W-1:0] attr;
        console_result_t   expected_q [$];
        int                errors;
        int                print_count;
        int                read_count;
        int                scroll_count;

        function new();
            foreach (cells[i]) cells[i] = '0;
            cur          = 0;
            attr         = ATTR_RESET;
            errors       = 0;
            print_count  = 0;
            read_count   = 0;
            scroll_count = 0;
        endfunction

        function void set_attr(logic [ATTR_W-1:0] value);
            attr = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // work out the result of one accepted input transaction
        function void note_input(logic op, logic [CHAR_W-1:0] ch, logic [POS_W-1:0] idx);
            console_result_t res;
            int unsigned     p;
            int unsigned     t;
            int unsigned     r;
            int              i;
            res = '0;
            if (op == OP_READ)
            begin
                read_count++;
                if (idx < CELLS)
                    res.data = cells[idx];
            end
            else
            begin
                print_count++;
                p = cur;
                if (p >= CELLS)
                    p = 0;
                case (ch)
                    CHAR_NEWLINE: p = (p / COLS + 1) * COLS;
                    CHAR_RETURN:  p = (p / COLS) * COLS;
                    CHAR_TAB:
                    begin
                        t = (p / TABW + 1) * TABW;
                        r = (p / COLS + 1) * COLS;
                        p = (t < r) ? t : r;
                    end
                    default:
                    begin
                        cells[p] = {attr, ch};
                        p++;
                    end
                endcase
                // scroll everything up one row, clear the bottom row
                if (p >= CELLS)
                begin
                    for (i = 0; i < CELLS - COLS; i++)
                        cells[i] = cells[i + COLS];
                    for (i = CELLS - COLS; i < CELLS; i++)
                        cells[i] = '0;
                    p -= COLS;
                    res.scr = 1'b1;
                    scroll_count++;
                end
                cur = p;
            end
            res.pos = cur[POS_W-1:0];
            expected_q.push_back(res);
        endfunction

        // compare one accepted result transaction with the oldest expectation
        function void check_result(logic [POS_W-1:0] pos, logic [DATA_W-1:0] data, logic scr);
            console_result_t exp_res;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result pos=%0d data=%h scrolled=%b",
                             $realtime, pos, data, scr);
                return;
            end
            exp_res = expected_q.pop_front();
            if (exp_res.pos !== pos || exp_res.data !== data || exp_res.scr !== scr)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch exp pos=%0d data=%h scrolled=%b, %s=%0d %s=%h %s=%b",
                             $realtime, exp_res.pos, exp_res.data, exp_res.scr,
                             "got pos", pos, "data", data, "scrolled", scr);
            end
        endfunction
    endclass

    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              cfg_write_en   = 1'b0;
    logic [ATTR_W-1:0] cfg_write_data = '0;
    logic              in_valid       = 1'b0;
    logic              in_stall;
    logic              operation      = OP_PRINT;
    logic [CHAR_W-1:0] char_code      = '0;
    logic [POS_W-1:0]  cell_index     = '0;
    logic              out_valid;
    logic              out_stall      = 1'b0;
    logic [POS_W-1:0]  cursor_pos;
    logic [DATA_W-1:0] read_data;
    logic              scrolled;

    int tx_idle_pct = 34;
    int rx_idle_pct = 84;

    console_scoreboard sb = new();

    text_console_char_writer i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .operation      (operation),
        .char_code      (char_code),
        .cell_index     (cell_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cursor_pos     (cursor_pos),
        .read_data      (read_data),
        .scrolled       (scrolled)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side: check accepted transactions, stall at random
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(cursor_pos, read_data, scrolled);
        out_stall <= (rx_idle_pct != 0) && ($urandom_range(99) < rx_idle_pct);
    end

    // present one input transaction and wait until it is taken
    task automatic send_item(input logic op, input logic [CHAR_W-1:0] ch,
                             input logic [POS_W-1:0] idx);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        char_code  <= ch;
        cell_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_input(op, ch, idx);
    endtask

    // hold off input until every expected result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // attribute write while the block is idle
    task automatic write_attr(input logic [ATTR_W-1:0] value);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        sb.set_attr(value);
        cfg_write_en   <= 1'b0;
    endtask

    // mostly prints with frequent line control, reads spread over the screen
    task automatic send_random_item();
        logic [CHAR_W-1:0] ch;
        logic [POS_W-1:0]  idx;
        int                sel;
        int                back;
        sel = $urandom_range(99);
        if (sel < 55)
        begin
            sel = $urandom_range(99);
            if (sel < 22)
                ch = CHAR_NEWLINE;
            else if (sel < 30)
                ch = CHAR_TAB;
            else if (sel < 36)
                ch = CHAR_RETURN;
            else
                ch = CHAR_W'($urandom_range(255));
            send_item(OP_PRINT, ch, POS_W'($urandom_range(2047)));
        end
        else
        begin
            sel = $urandom_range(3);
            if (sel == 0)
            begin
                idx = POS_W'($urandom_range(2047));
            end
            else if (sel == 1)
            begin
                back = $urandom_range(COLS);
                idx  = (sb.cur > back) ? POS_W'(sb.cur - back) : '0;
            end
            else
            begin
                idx = POS_W'($urandom_range(CELLS - 1));
            end
            send_item(OP_READ, CHAR_W'($urandom_range(255)), idx);
        end
    endtask

    // a run of plain characters, so that a character itself can run off the screen
    task automatic send_text_burst(input int count);
        logic [CHAR_W-1:0] ch;
        int                n;
        for (n = 0; n < count; n++)
        begin
            ch = CHAR_W'($urandom_range(255));
            if (ch == CHAR_NEWLINE || ch == CHAR_RETURN || ch == CHAR_TAB)
                ch = 8'h20;
            send_item(OP_PRINT, ch, POS_W'($urandom_range(2047)));
        end
    endtask

    // watchdog
    initial
    begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // main sequence
    initial
    begin
        int n;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reads of a cleared screen, edge characters, control codes
        send_item(OP_READ, 8'h00, 11'd0);
        send_item(OP_READ, 8'hFF, 11'd1999);
        send_item(OP_READ, 8'h00, 11'd2000);
        send_item(OP_READ, 8'hFF, 11'd2047);
        send_item(OP_PRINT, 8'h41, 11'd0);
        send_item(OP_PRINT, 8'h00, 11'd2047);
        send_item(OP_PRINT, 8'hFF, 11'd0);
        send_item(OP_READ, 8'h00, 11'd0);
        send_item(OP_READ, 8'h00, 11'd1);
        send_item(OP_READ, 8'h00, 11'd2);
        send_item(OP_PRINT, CHAR_TAB, 11'd0);
        send_item(OP_PRINT, CHAR_TAB, 11'd0);
        send_item(OP_PRINT, 8'h78, 11'd0);
        send_item(OP_PRINT, CHAR_RETURN, 11'd0);
        send_item(OP_PRINT, 8'h5A, 11'd0);
        send_item(OP_PRINT, CHAR_NEWLINE, 11'd0);
        send_item(OP_PRINT, CHAR_NEWLINE, 11'd0);
        send_item(OP_PRINT, 8'h7F, 11'd0);
        send_item(OP_PRINT, CHAR_TAB, 11'd0);
        send_item(OP_PRINT, CHAR_RETURN, 11'd0);
        send_item(OP_READ, 8'h00, 11'd160);
        send_item(OP_READ, 8'h00, 11'd16);
        drain_results();

        // phase a: sender idles lightly, receiver heavily, attribute zero
        write_attr(8'h00);
        for (n = 0; n < 110; n++)
        begin
            send_random_item();
            if (n == 60)
                drain_results();
        end
        drain_results();

        // phase b: roles swapped, attribute all ones
        tx_idle_pct = 84;
        rx_idle_pct = 34;
        write_attr(8'hFF);
        for (n = 0; n < 110; n++)
            send_random_item();
        drain_results();

        // phase c: no idling, random attribute, one long line of text
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_attr(ATTR_W'($urandom_range(255)));
        for (n = 0; n < 50; n++)
            send_random_item();
        send_text_burst(82);
        for (n = 0; n < 50; n++)
            send_random_item();

        // wind down
        drain_results();
        repeat (10) @(posedge clk);

        $display("covered %0d prints, %0d reads and %0d scrolls", sb.print_count,
                 sb.read_count, sb.scroll_count);
        $display("attribute reset value, 0x00, 0xff and a random value under three idle mixes");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/tccw_pkg.sv
rtl/tccw_screen_ram.sv
rtl/tccw_cursor.sv
rtl/tccw_seq.sv
rtl/text_console_char_writer.sv
rtl/tccw_checker.sv
sim/tb_text_console_char_writer.sv
